>>> src/lcabl_pkg.sv
// Package for the binary lifting LCA engine: widths, payload structs,
// function codes, controller states and the controller/datapath interface.
// No dependencies.
package lcabl_pkg;

    localparam int NODE_W = 10;
    localparam int TIME_W = 11;
    localparam int TOP_W  = 4;
    localparam int LEVELS = 11;
    localparam int LVL_W  = $clog2(LEVELS + 1);
    localparam int ANC_AW = NODE_W + LVL_W;

    localparam logic [TOP_W-1:0] TOP_RESET = 4'd10;
    localparam logic [LVL_W-1:0] LVL_MAX   = LVL_W'(LEVELS - 1);
    localparam logic [LVL_W-1:0] LVL_END   = LVL_W'(LEVELS);

    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    typedef struct packed {
        logic              func;
        logic [NODE_W-1:0] node;
        logic [NODE_W-1:0] parent_node;
        logic [TIME_W-1:0] enter_time;
        logic [TIME_W-1:0] leave_time;
        logic [NODE_W-1:0] other_node;
    } t_lcabl_in;

    typedef struct packed {
        logic [NODE_W-1:0] ancestor;
        logic              is_answer;
    } t_lcabl_out;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LD_RD,
        ST_LD_WR,
        ST_Q_TA,
        ST_Q_TB,
        ST_Q_CMP,
        ST_C_RA,
        ST_C_RT,
        ST_C_CMP,
        ST_Q_PAR,
        ST_Q_PRD,
        ST_FINISH
    } t_lcabl_state;

    typedef enum logic [1:0] {
        TSEL_NODE,
        TSEL_OTHER,
        TSEL_UP
    } t_lcabl_tsel;

    typedef enum logic [1:0] {
        RES_NONE,
        RES_CONTAIN,
        RES_ANC
    } t_lcabl_res;

    typedef struct packed {
        logic        capture;
        logic        anc_rd;
        logic        anc_rd_prev;
        logic        anc_wr;
        logic        anc_wr_zero;
        logic        cur_from_anc;
        logic        lvl_inc;
        logic        lvl_dec;
        logic        lvl_load_top;
        logic        time_rd;
        t_lcabl_tsel time_sel;
        logic        latch_a;
        logic        latch_b;
        logic        up_latch;
        logic        cmp_update;
        t_lcabl_res  res_sel;
        logic        out_load;
    } t_lcabl_cmd;

    typedef struct packed {
        logic node_zero;
        logic lvl_done;
        logic lvl_above_top;
        logic lvl_zero;
        logic a_has_b;
        logic b_has_a;
        logic out_free;
    } t_lcabl_sts;

endpackage

>>> src/lcabl_ctrl.sv
// Controller state machine of the LCA engine: sequences loads and queries.
// Depends on lcabl_pkg; drives the datapath through t_lcabl_cmd.
module lcabl_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_func,
    input  lcabl_pkg::t_lcabl_sts i_sts,
    output lcabl_pkg::t_lcabl_cmd o_cmd,
    output logic                 o_ready
);

    lcabl_pkg::t_lcabl_state r_state;
    lcabl_pkg::t_lcabl_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lcabl_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            lcabl_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = (i_in_func == lcabl_pkg::FUNC_LOAD) ?
                              lcabl_pkg::ST_LD_RD : lcabl_pkg::ST_Q_TA;
                end
            end
            lcabl_pkg::ST_LD_RD: begin
                if (i_sts.node_zero || i_sts.lvl_done) begin
                    n_state = lcabl_pkg::ST_FINISH;
                end else if (!i_sts.lvl_above_top) begin
                    n_state = lcabl_pkg::ST_LD_WR;
                end
            end
            lcabl_pkg::ST_LD_WR:  n_state = lcabl_pkg::ST_LD_RD;
            lcabl_pkg::ST_Q_TA:   n_state = lcabl_pkg::ST_Q_TB;
            lcabl_pkg::ST_Q_TB:   n_state = lcabl_pkg::ST_Q_CMP;
            lcabl_pkg::ST_Q_CMP: begin
                n_state = (i_sts.a_has_b || i_sts.b_has_a) ?
                          lcabl_pkg::ST_FINISH : lcabl_pkg::ST_C_RA;
            end
            lcabl_pkg::ST_C_RA:   n_state = lcabl_pkg::ST_C_RT;
            lcabl_pkg::ST_C_RT:   n_state = lcabl_pkg::ST_C_CMP;
            lcabl_pkg::ST_C_CMP: begin
                n_state = i_sts.lvl_zero ? lcabl_pkg::ST_Q_PAR : lcabl_pkg::ST_C_RA;
            end
            lcabl_pkg::ST_Q_PAR:  n_state = lcabl_pkg::ST_Q_PRD;
            lcabl_pkg::ST_Q_PRD:  n_state = lcabl_pkg::ST_FINISH;
            lcabl_pkg::ST_FINISH: begin
                if (i_sts.out_free) begin
                    n_state = lcabl_pkg::ST_IDLE;
                end
            end
            default: n_state = lcabl_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd          = '0;
        o_cmd.time_sel = lcabl_pkg::TSEL_NODE;
        o_cmd.res_sel  = lcabl_pkg::RES_NONE;
        o_ready        = 1'b0;
        case (r_state)
            lcabl_pkg::ST_IDLE: begin
                o_ready       = 1'b1;
                o_cmd.capture = i_in_valid;
            end
            lcabl_pkg::ST_LD_RD: begin
                if (!i_sts.node_zero && !i_sts.lvl_done) begin
                    if (i_sts.lvl_above_top) begin
                        // Levels above the configured top are stored as zero.
                        o_cmd.anc_wr      = 1'b1;
                        o_cmd.anc_wr_zero = 1'b1;
                        o_cmd.lvl_inc     = 1'b1;
                    end else begin
                        o_cmd.anc_rd      = 1'b1;
                        o_cmd.anc_rd_prev = 1'b1;
                    end
                end
            end
            lcabl_pkg::ST_LD_WR: begin
                o_cmd.anc_wr       = 1'b1;
                o_cmd.cur_from_anc = 1'b1;
                o_cmd.lvl_inc      = 1'b1;
            end
            lcabl_pkg::ST_Q_TA: begin
                o_cmd.time_rd  = 1'b1;
                o_cmd.time_sel = lcabl_pkg::TSEL_NODE;
            end
            lcabl_pkg::ST_Q_TB: begin
                o_cmd.time_rd  = 1'b1;
                o_cmd.time_sel = lcabl_pkg::TSEL_OTHER;
                o_cmd.latch_a  = 1'b1;
            end
            lcabl_pkg::ST_Q_CMP: begin
                o_cmd.latch_b      = 1'b1;
                o_cmd.lvl_load_top = 1'b1;
                o_cmd.res_sel      = lcabl_pkg::RES_CONTAIN;
            end
            lcabl_pkg::ST_C_RA: begin
                o_cmd.anc_rd = 1'b1;
            end
            lcabl_pkg::ST_C_RT: begin
                o_cmd.time_rd  = 1'b1;
                o_cmd.time_sel = lcabl_pkg::TSEL_UP;
                o_cmd.up_latch = 1'b1;
            end
            lcabl_pkg::ST_C_CMP: begin
                o_cmd.cmp_update = 1'b1;
                o_cmd.lvl_dec    = !i_sts.lvl_zero;
            end
            lcabl_pkg::ST_Q_PAR: begin
                o_cmd.anc_rd = 1'b1;
            end
            lcabl_pkg::ST_Q_PRD: begin
                o_cmd.res_sel = lcabl_pkg::RES_ANC;
            end
            lcabl_pkg::ST_FINISH: begin
                o_cmd.out_load = i_sts.out_free;
            end
            default: begin
                o_ready = 1'b0;
            end
        endcase
    end

endmodule

>>> src/lcabl_datapath.sv
// Datapath of the LCA engine: ancestor and time memories, level counter,
// interval compares, configuration register and output register.
// Depends on lcabl_pkg; commanded by lcabl_ctrl.
module lcabl_datapath (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [lcabl_pkg::TOP_W-1:0]         i_cfg_wdata,
    input  lcabl_pkg::t_lcabl_in                i_in_data,
    input  lcabl_pkg::t_lcabl_cmd               i_cmd,
    input  logic                                i_out_stall,
    output lcabl_pkg::t_lcabl_sts               o_sts,
    output logic                                o_out_valid,
    output lcabl_pkg::t_lcabl_out               o_out_data
);

    localparam int NW = lcabl_pkg::NODE_W;
    localparam int TW = lcabl_pkg::TIME_W;
    localparam int LW = lcabl_pkg::LVL_W;
    localparam int AW = lcabl_pkg::ANC_AW;
    localparam int ANC_DEPTH  = 2 ** AW;
    localparam int NODE_DEPTH = 2 ** NW;

    logic [NW-1:0] r_anc_mem  [ANC_DEPTH];
    logic [TW-1:0] r_tin_mem  [NODE_DEPTH];
    logic [TW-1:0] r_tout_mem [NODE_DEPTH];

    lcabl_pkg::t_lcabl_in  r_item;
    lcabl_pkg::t_lcabl_out r_out_data;
    logic                  r_out_valid;
    logic [lcabl_pkg::TOP_W-1:0] r_top;
    logic [NW-1:0] r_cur;
    logic [NW-1:0] r_up;
    logic [NW-1:0] r_res;
    logic [LW-1:0] r_lvl;
    logic [NW-1:0] r_anc_rd;
    logic          r_anc_zero;
    logic [TW-1:0] r_tin_rd;
    logic [TW-1:0] r_tout_rd;
    logic [TW-1:0] r_a_tin;
    logic [TW-1:0] r_a_tout;
    logic [TW-1:0] r_b_tin;
    logic [TW-1:0] r_b_tout;

    logic [LW-1:0] w_top_used;
    logic [NW-1:0] w_anc_val;
    logic [LW-1:0] w_rd_lvl;
    logic [AW-1:0] w_anc_raddr;
    logic          w_anc_we;
    logic [AW-1:0] w_anc_waddr;
    logic [NW-1:0] w_anc_wdata;
    logic          w_load_ok;
    logic [NW-1:0] w_time_addr;
    logic          w_up_has_b;

    // A top level beyond the table depth is clamped to the last level.
    assign w_top_used = (LW'(r_top) > lcabl_pkg::LVL_MAX) ? lcabl_pkg::LVL_MAX : LW'(r_top);

    // Node zero is the "no parent" node and its row always reads as zero.
    assign w_anc_val = r_anc_zero ? '0 : r_anc_rd;

    assign w_rd_lvl    = i_cmd.anc_rd_prev ? (r_lvl - LW'(1)) : r_lvl;
    assign w_anc_raddr = {r_cur, w_rd_lvl};

    assign w_load_ok = (i_in_data.func == lcabl_pkg::FUNC_LOAD) && (i_in_data.node != '0);

    always_comb begin
        if (i_cmd.capture) begin
            w_anc_we    = w_load_ok;
            w_anc_waddr = {i_in_data.node, LW'(0)};
            w_anc_wdata = i_in_data.parent_node;
        end else begin
            w_anc_we    = i_cmd.anc_wr;
            w_anc_waddr = {r_item.node, r_lvl};
            w_anc_wdata = i_cmd.anc_wr_zero ? '0 : w_anc_val;
        end
    end

    always_comb begin
        case (i_cmd.time_sel)
            lcabl_pkg::TSEL_NODE:  w_time_addr = r_item.node;
            lcabl_pkg::TSEL_OTHER: w_time_addr = r_item.other_node;
            lcabl_pkg::TSEL_UP:    w_time_addr = w_anc_val;
            default:               w_time_addr = r_item.node;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_anc_we) begin
            r_anc_mem[w_anc_waddr] <= w_anc_wdata;
        end
        if (i_cmd.anc_rd) begin
            r_anc_rd   <= r_anc_mem[w_anc_raddr];
            r_anc_zero <= (r_cur == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture && w_load_ok) begin
            r_tin_mem[i_in_data.node]  <= i_in_data.enter_time;
            r_tout_mem[i_in_data.node] <= i_in_data.leave_time;
        end
        if (i_cmd.time_rd) begin
            r_tin_rd  <= r_tin_mem[w_time_addr];
            r_tout_rd <= r_tout_mem[w_time_addr];
        end
    end

    // In the compare state the second node's times sit in the read registers.
    assign o_sts.a_has_b = (r_a_tin <= r_tin_rd) && (r_tout_rd <= r_a_tout);
    assign o_sts.b_has_a = (r_tin_rd <= r_a_tin) && (r_a_tout <= r_tout_rd);
    assign w_up_has_b    = (r_tin_rd <= r_b_tin) && (r_b_tout <= r_tout_rd);

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_item <= i_in_data;
            r_lvl  <= LW'(1);
            r_cur  <= (i_in_data.func == lcabl_pkg::FUNC_LOAD) ?
                      i_in_data.parent_node : i_in_data.node;
        end else begin
            if (i_cmd.lvl_load_top) begin
                r_lvl <= w_top_used;
            end else if (i_cmd.lvl_inc) begin
                r_lvl <= r_lvl + LW'(1);
            end else if (i_cmd.lvl_dec) begin
                r_lvl <= r_lvl - LW'(1);
            end
            if (i_cmd.cur_from_anc) begin
                r_cur <= w_anc_val;
            end else if (i_cmd.cmp_update && (r_up != '0) && !w_up_has_b) begin
                r_cur <= r_up;
            end
        end
        if (i_cmd.latch_a) begin
            r_a_tin  <= r_tin_rd;
            r_a_tout <= r_tout_rd;
        end
        if (i_cmd.latch_b) begin
            r_b_tin  <= r_tin_rd;
            r_b_tout <= r_tout_rd;
        end
        if (i_cmd.up_latch) begin
            r_up <= w_anc_val;
        end
        case (i_cmd.res_sel)
            lcabl_pkg::RES_CONTAIN: r_res <= o_sts.a_has_b ? r_item.node : r_item.other_node;
            lcabl_pkg::RES_ANC:     r_res <= w_anc_val;
            default:                r_res <= r_res;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_top <= lcabl_pkg::TOP_RESET;
        end else if (i_cfg_we) begin
            r_top <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_data.is_answer <= r_item.func;
            r_out_data.ancestor  <= (r_item.func == lcabl_pkg::FUNC_QUERY) ? r_res : '0;
        end
    end

    assign o_sts.node_zero     = (r_item.node == '0);
    assign o_sts.lvl_done      = (r_lvl == lcabl_pkg::LVL_END);
    assign o_sts.lvl_above_top = (r_lvl > w_top_used);
    assign o_sts.lvl_zero      = (r_lvl == '0);
    assign o_sts.out_free      = !r_out_valid || !i_out_stall;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    a_out_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> (!r_out_valid || !i_out_stall))
        else $error("result loaded while a stalled result is pending");

    a_single_anc_writer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.capture |-> !i_cmd.anc_wr)
        else $error("two writers on the ancestor memory");

    a_climb_start_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.lvl_load_top |=> (r_lvl <= lcabl_pkg::LVL_MAX))
        else $error("climb starts beyond the last level");

    a_load_write_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.anc_wr && !i_cmd.capture) |-> (r_lvl != '0 && r_lvl <= lcabl_pkg::LVL_MAX))
        else $error("load chain writes outside levels one to last");

endmodule

>>> src/lca_binary_lifting_engine_core.sv
// Top level of the binary lifting lowest common ancestor engine.
// Depends on lcabl_pkg, lcabl_ctrl and lcabl_datapath.
//
// One item is in work at a time; every item gives exactly one result beat.
// With T the effective top level (the register value, clamped to 10), a load
// takes one read-then-write step per filled ancestor level and one step per
// level written as zero. A query whose nodes are nested ends after the time
// reads of both nodes and their interval compare; otherwise it then climbs
// from level T, with the ancestor read, the time read of that ancestor and the
// interval compare for each level. This step structure is set by the single
// read port of the ancestor memory and of the time memories, each with a
// registered read. A result beat waits in an output register, and the next
// input beat is taken as soon as the previous result is registered.
// Entries of the time memories read before being written hold no defined value.
module lca_binary_lifting_engine_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [lcabl_pkg::TOP_W-1:0] i_cfg_wdata,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  lcabl_pkg::t_lcabl_in        i_in_data,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output lcabl_pkg::t_lcabl_out       o_out_data
);

    lcabl_pkg::t_lcabl_cmd w_cmd;
    lcabl_pkg::t_lcabl_sts w_sts;
    logic                  w_ready;

    lcabl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_func  (i_in_data.func),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd),
        .o_ready    (w_ready)
    );

    lcabl_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_data   (i_in_data),
        .i_cmd       (w_cmd),
        .i_out_stall (i_out_stall),
        .o_sts       (w_sts),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

    assign o_in_stall = !w_ready;

endmodule
